/* rtl/wpct_pkg.sv */
package wpct_pkg;

    localparam int NUM_CONTRACTS_DEF = 64;
    localparam int RING_DEPTH_DEF    = 256;
    localparam int NUM_WIN           = 3;

    localparam logic [15:0] SHORT_RESET = 16'd60;
    localparam logic [15:0] MID_RESET   = 16'd180;
    localparam logic [15:0] LONG_RESET  = 16'd300;

    localparam logic [1:0] REG_SHORT = 2'd0;
    localparam logic [1:0] REG_MID   = 2'd1;
    localparam logic [1:0] REG_LONG  = 2'd2;

    localparam logic signed [20:0] CHANGE_MAX = 21'sd1000000;
    localparam logic [13:0]        SCALE      = 14'd10000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_META,
        ST_RD_OLD,
        ST_CHECK,
        ST_WRITE,
        ST_RD_BASE,
        ST_DIV,
        ST_NEXT,
        ST_OUT
    } state_t;

endpackage

/* rtl/windowed_price_change_tracker_unit.sv */
// The work per word grows with its age checks: one per expired entry plus one per window
// whose ring stays non-empty.
// A window with a zero base skips the 56 divider steps of its restoring division.
// One word at a time: the next word is taken in the cycle after its result is loaded; a stalled
// result holds the unit in its output state.
// Reset (rst_n, async low) clears ring heads/counts via valid bits, windows to 60/180/300 s.
module windowed_price_change_tracker_unit #(
    parameter int NUM_CONTRACTS = wpct_pkg::NUM_CONTRACTS_DEF,
    parameter int RING_DEPTH    = wpct_pkg::RING_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [5:0]         contract_index,
    input  logic [31:0]        tick_seconds,
    input  logic [39:0]        tick_price,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [5:0]         result_contract,
    output logic signed [20:0] short_change,
    output logic signed [20:0] mid_change,
    output logic signed [20:0] long_change,
    output logic [2:0]         zero_base_mask,
    output logic [2:0]         overflow_mask,
    output logic [2:0]         saturated_mask
);
    localparam int NRINGS = NUM_CONTRACTS * 3;
    localparam int RW     = (NRINGS > 1) ? $clog2(NRINGS) : 1;
    localparam int HW     = $clog2(RING_DEPTH);
    localparam int CW     = $clog2(RING_DEPTH + 1);
    localparam int AW     = $clog2(NRINGS * RING_DEPTH);
    localparam int DEPTH  = NRINGS * RING_DEPTH;
    localparam int NUMW   = 56;  // mag*10000*2 + base fits
    localparam int DSTEPS = NUMW + 1;  // numerator load, then one step per bit
    localparam int DCW    = $clog2(DSTEPS + 1);
    localparam logic [CW-1:0] FULL = CW'(RING_DEPTH);

    // window registers
    logic [15:0] win_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg[0] <= wpct_pkg::SHORT_RESET;
            win_reg[1] <= wpct_pkg::MID_RESET;
            win_reg[2] <= wpct_pkg::LONG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wpct_pkg::REG_SHORT: win_reg[0] <= cfg_data;
                wpct_pkg::REG_MID:   win_reg[1] <= cfg_data;
                wpct_pkg::REG_LONG:  win_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // ring metadata memory, valid bits give reset zero
    logic [HW+CW-1:0] meta_mem [NRINGS];
    logic [NRINGS-1:0] meta_vld_reg;
    logic [HW+CW-1:0] meta_q;
    logic             meta_qv;
    logic             meta_we;
    logic [RW-1:0]    ring_reg;
    logic [HW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg, count_next;

    // entry memory: time and price
    logic [71:0]   ent_mem [DEPTH];
    logic [71:0]   ent_q;
    logic          ent_we;
    logic [AW-1:0] ent_addr;
    logic [71:0]   ent_wd;

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_addr] <= ent_wd;
        ent_q <= ent_mem[ent_addr];
        if (meta_we)
            meta_mem[ring_reg] <= {head_reg, count_reg};
        meta_q <= meta_mem[ring_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_vld_reg <= '0;
            meta_qv      <= 1'b0;
        end
        else
        begin
            if (meta_we)
                meta_vld_reg[ring_reg] <= 1'b1;
            meta_qv <= meta_vld_reg[ring_reg];
        end
    end

    // control
    wpct_pkg::state_t state_reg, state_next;
    logic [1:0]  win_reg_i, win_next;
    logic [5:0]  ctr_reg;
    logic [31:0] t_reg;
    logic [39:0] p_reg;
    logic [39:0] base_reg, base_next;
    logic [2:0]  zb_reg, zb_next, ov_reg, ov_next, sat_reg, sat_next;
    logic signed [20:0] chg_reg [3];
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic [NUMW-1:0] num_reg, num_next, quo_reg, quo_next;
    logic [41:0]     rem_reg, rem_next;
    logic            neg_reg, neg_next;
    logic            stall_free;

    logic [RW-1:0] slot;
    logic [RW+1:0] ring_calc;
    assign slot      = RW'(32'(contract_index) % NUM_CONTRACTS);
    assign ring_calc = (RW+2)'(slot) * (RW+2)'(3) + (RW+2)'(win_reg_i);

    logic signed [32:0] age;
    assign age = $signed({1'b0, t_reg}) - $signed({1'b0, ent_q[71:40]});

    logic [CW:0] hc_sum;
    assign hc_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);

    logic [AW-1:0] ring_base;
    assign ring_base = AW'(ring_reg) * AW'(RING_DEPTH);

    logic [42:0] rem_sh;
    logic [41:0] dvs;
    assign dvs    = {1'b0, base_reg, 1'b0};
    assign rem_sh = {rem_reg, num_reg[NUMW-1]};

    logic [40:0] mag;
    assign mag = (p_reg < base_reg) ? 41'(base_reg - p_reg) : 41'(p_reg - base_reg);

    assign stall_free = !out_valid || !out_stall;
    assign in_stall   = (state_reg != wpct_pkg::ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wpct_pkg::ST_IDLE:    if (in_valid) state_next = wpct_pkg::ST_RD_META;
            wpct_pkg::ST_RD_META: state_next = wpct_pkg::ST_RD_OLD;
            wpct_pkg::ST_RD_OLD:  state_next = (count_next == '0) ? wpct_pkg::ST_WRITE
                                                                  : wpct_pkg::ST_CHECK;
            wpct_pkg::ST_CHECK:
                if (age > $signed({17'd0, win_reg[win_reg_i]}) && count_reg != '0)
                    state_next = (count_reg == CW'(1)) ? wpct_pkg::ST_WRITE
                                                       : wpct_pkg::ST_CHECK;
                else
                    state_next = wpct_pkg::ST_WRITE;
            wpct_pkg::ST_WRITE:   state_next = wpct_pkg::ST_RD_BASE;
            wpct_pkg::ST_RD_BASE: state_next = wpct_pkg::ST_DIV;
            wpct_pkg::ST_DIV:
                if (dcnt_reg == DCW'(DSTEPS) || (dcnt_reg != '0 && base_reg == '0))
                    state_next = wpct_pkg::ST_NEXT;
            wpct_pkg::ST_NEXT:    state_next = (win_reg_i == 2'd2) ? wpct_pkg::ST_OUT
                                                                  : wpct_pkg::ST_RD_META;
            wpct_pkg::ST_OUT:     if (stall_free) state_next = wpct_pkg::ST_IDLE;
            default:              state_next = wpct_pkg::ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        win_next   = win_reg_i;
        head_next  = head_reg;
        count_next = count_reg;
        base_next  = base_reg;
        zb_next    = zb_reg;
        ov_next    = ov_reg;
        sat_next   = sat_reg;
        dcnt_next  = dcnt_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        meta_we    = 1'b0;
        ent_we     = 1'b0;
        ent_wd     = {t_reg, p_reg};
        ent_addr   = ring_base + AW'(head_reg);
        case (state_reg)
            wpct_pkg::ST_IDLE:
            begin
                win_next = 2'd0;
                zb_next  = '0;
                ov_next  = '0;
                sat_next = '0;
            end
            wpct_pkg::ST_RD_META: ;
            wpct_pkg::ST_RD_OLD:
            begin
                head_next  = meta_qv ? meta_q[HW+CW-1:CW] : '0;
                count_next = meta_qv ? meta_q[CW-1:0] : '0;
                ent_addr   = ring_base + AW'(head_next);
            end
            wpct_pkg::ST_CHECK:
                if (age > $signed({17'd0, win_reg[win_reg_i]}))
                begin
                    head_next  = HW'((32'(head_reg) + 1) % RING_DEPTH);
                    count_next = count_reg - CW'(1);
                    ent_addr   = ring_base + AW'(head_next);
                end
            wpct_pkg::ST_WRITE:
            begin
                ent_we = 1'b1;
                if (count_reg >= FULL)
                begin
                    ov_next[win_reg_i] = 1'b1;
                    ent_addr  = ring_base + AW'(head_reg);
                    head_next = HW'((32'(head_reg) + 1) % RING_DEPTH);
                end
                else
                begin
                    ent_addr   = ring_base + AW'((32'(hc_sum)) % RING_DEPTH);
                    count_next = count_reg + CW'(1);
                end
            end
            wpct_pkg::ST_RD_BASE:
            begin
                meta_we  = 1'b1;
                ent_addr = ring_base + AW'(head_reg);
            end
            wpct_pkg::ST_DIV:
                if (dcnt_reg == '0)
                begin
                    base_next = ent_q[39:0];
                    dcnt_next = DCW'(1);
                end
                else if (dcnt_reg == DCW'(1))
                begin
                    // numerator 2*mag*10000 + base
                    num_next  = NUMW'(mag) * NUMW'(2 * 10000) + NUMW'(base_reg);
                    neg_next  = p_reg < base_reg;
                    rem_next  = '0;
                    quo_next  = '0;
                    dcnt_next = DCW'(2);
                end
                else
                begin
                    if (rem_sh >= {1'b0, dvs})
                    begin
                        rem_next = 42'(rem_sh - {1'b0, dvs});
                        quo_next = {quo_reg[NUMW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh[41:0];
                        quo_next = {quo_reg[NUMW-2:0], 1'b0};
                    end
                    num_next  = {num_reg[NUMW-2:0], 1'b0};
                    dcnt_next = dcnt_reg + DCW'(1);
                end
            wpct_pkg::ST_NEXT:
            begin
                dcnt_next = '0;
                win_next  = (win_reg_i == 2'd2) ? 2'd0 : win_reg_i + 2'd1;
                if (base_reg == '0)
                    zb_next[win_reg_i] = 1'b1;
                else if (!neg_reg && quo_reg > NUMW'(1000000))
                    sat_next[win_reg_i] = 1'b1;
            end
            default: ;
        endcase
    end

    // final change per window from the rounded quotient
    logic signed [20:0] chg_now;
    always_comb
    begin
        if (base_reg == '0)
            chg_now = '0;
        else if (neg_reg)
            chg_now = (quo_reg > NUMW'(10000)) ? -21'sd10000 : -$signed(21'(quo_reg));
        else if (quo_reg > NUMW'(1000000))
            chg_now = wpct_pkg::CHANGE_MAX;
        else
            chg_now = $signed(21'(quo_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wpct_pkg::ST_IDLE;
            win_reg_i <= 2'd0;
            dcnt_reg  <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            win_reg_i <= win_next;
            dcnt_reg  <= (state_reg == wpct_pkg::ST_DIV && base_reg == '0 &&
                          dcnt_reg != '0) ? DCW'(0) : dcnt_next;
            if (state_reg == wpct_pkg::ST_OUT && stall_free)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == wpct_pkg::ST_IDLE && in_valid)
        begin
            ctr_reg <= contract_index;
            t_reg   <= tick_seconds;
            p_reg   <= tick_price;
        end
        if (state_reg == wpct_pkg::ST_IDLE)
            ring_reg <= RW'(ring_calc);
        else if (state_reg == wpct_pkg::ST_NEXT)
            ring_reg <= RW'(ring_reg + RW'(1));
        head_reg  <= head_next;
        count_reg <= count_next;
        base_reg  <= base_next;
        zb_reg    <= zb_next;
        ov_reg    <= ov_next;
        sat_reg   <= sat_next;
        num_reg   <= num_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        neg_reg   <= neg_next;
        if (state_reg == wpct_pkg::ST_NEXT)
            chg_reg[win_reg_i] <= chg_now;
        if (state_reg == wpct_pkg::ST_OUT && stall_free)
        begin
            result_contract <= ctr_reg;
            short_change    <= chg_reg[0];
            mid_change      <= chg_reg[1];
            long_change     <= chg_reg[2];
            zero_base_mask  <= zb_reg;
            overflow_mask   <= ov_reg;
            saturated_mask  <= sat_reg;
        end
    end

    // checks
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != wpct_pkg::ST_IDLE |-> in_stall)
        else $error("busy without stall");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wpct_pkg::ST_CHECK |-> count_reg <= FULL)
        else $error("ring count beyond depth");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(short_change))
        else $error("result dropped under stall");
    a_win_range: assert property (@(posedge clk) disable iff (!rst_n)
        win_reg_i != 2'd3)
        else $error("window index out of range");

endmodule

/* sim/tick_change_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the tracker, predicts every result word and compares.
module tick_change_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [5:0]         contract_index,
    input  logic [31:0]        tick_seconds,
    input  logic [39:0]        tick_price,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [5:0]         result_contract,
    input  logic signed [20:0] short_change,
    input  logic signed [20:0] mid_change,
    input  logic signed [20:0] long_change,
    input  logic [2:0]         zero_base_mask,
    input  logic [2:0]         overflow_mask,
    input  logic [2:0]         saturated_mask,
    output int                 error_count,
    output int                 pending_count
);

    localparam int NRINGS = wpct_pkg::NUM_CONTRACTS_DEF * wpct_pkg::NUM_WIN;
    localparam int RDEPTH = wpct_pkg::RING_DEPTH_DEF;

    typedef struct packed {
        logic [5:0]         contract;
        logic signed [20:0] chg_s;
        logic signed [20:0] chg_m;
        logic signed [20:0] chg_l;
        logic [2:0]         zb;
        logic [2:0]         ov;
        logic [2:0]         sat;
    } change_word_t;

    change_word_t expected_changes[$];

    logic [31:0] entry_time  [NRINGS][RDEPTH];
    logic [39:0] entry_price [NRINGS][RDEPTH];
    int          head_of     [NRINGS];
    int          count_of    [NRINGS];
    logic [15:0] window_len  [wpct_pkg::NUM_WIN];

    assign pending_count = expected_changes.size();

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // rounded percent change in hundredths, clipped
    function automatic logic signed [20:0] change_of(input logic [39:0] now,
                                                    input logic [39:0] base,
                                                    output logic clipped);
        logic [63:0] mag;
        logic [63:0] q;
        logic        neg;
        neg = now < base;
        clipped = 1'b0;
        mag = neg ? 64'(base - now) : 64'(now - base);
        mag = mag * 64'd10000;
        q = (64'd2 * mag + 64'(base)) / (64'd2 * 64'(base));
        if (neg)
        begin
            if (q > 64'd10000)
                q = 64'd10000;
            return -21'(q);
        end
        if (q > 64'd1000000)
        begin
            clipped = 1'b1;
            return wpct_pkg::CHANGE_MAX;
        end
        return 21'(q);
    endfunction

    // one window: expire, store, compare against oldest
    function automatic logic signed [20:0] step_window(input int ring, input logic [31:0] t,
                                                      input logic [39:0] price,
                                                      input logic [15:0] limit,
                                                      output logic zb, output logic ov,
                                                      output logic sat);
        int          h;
        int          c;
        int          pos;
        longint      age;
        logic [39:0] base;
        h = head_of[ring];
        c = count_of[ring];
        zb = 1'b0; ov = 1'b0; sat = 1'b0;
        while (c > 0)
        begin
            age = longint'(t) - longint'(entry_time[ring][h]);
            if (age > longint'(limit))
            begin
                h = (h + 1) % RDEPTH;
                c--;
            end
            else
                break;
        end
        if (c >= RDEPTH)
        begin
            ov = 1'b1;
            pos = h;
            h = (h + 1) % RDEPTH;
        end
        else
        begin
            pos = (h + c) % RDEPTH;
            c++;
        end
        entry_time[ring][pos] = t;
        entry_price[ring][pos] = price;
        head_of[ring] = h;
        count_of[ring] = c;
        base = entry_price[ring][h];
        if (base == '0)
        begin
            zb = 1'b1;
            return 21'sd0;
        end
        return change_of(price, base, sat);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        change_word_t e;
        change_word_t g;
        logic [2:0]   zb3;
        logic [2:0]   ov3;
        logic [2:0]   sat3;
        int           slot;
        if (!rst_n)
        begin
            expected_changes.delete();
            for (int r = 0; r < NRINGS; r++)
            begin
                head_of[r] = 0;
                count_of[r] = 0;
            end
            window_len[0] = wpct_pkg::SHORT_RESET;
            window_len[1] = wpct_pkg::MID_RESET;
            window_len[2] = wpct_pkg::LONG_RESET;
        end
        else
        begin
            if (cfg_we && cfg_index < wpct_pkg::NUM_WIN)
                window_len[cfg_index] = cfg_data;
            // predict on accepted input word
            if (in_valid && !in_stall)
            begin
                slot = int'(contract_index) % wpct_pkg::NUM_CONTRACTS_DEF;
                e.contract = contract_index;
                e.chg_s = step_window(slot * 3 + 0, tick_seconds, tick_price, window_len[0],
                                      zb3[0], ov3[0], sat3[0]);
                e.chg_m = step_window(slot * 3 + 1, tick_seconds, tick_price, window_len[1],
                                      zb3[1], ov3[1], sat3[1]);
                e.chg_l = step_window(slot * 3 + 2, tick_seconds, tick_price, window_len[2],
                                      zb3[2], ov3[2], sat3[2]);
                e.zb = zb3; e.ov = ov3; e.sat = sat3;
                expected_changes.insert(expected_changes.size(), e);
            end
            // compare on accepted output word
            if (out_valid && !out_stall)
            begin
                if (expected_changes.size() == 0)
                begin
                    $display("%0t: result word with nothing expected", $realtime);
                    error_count++;
                end
                else
                begin
                    e = expected_changes[0];
                    expected_changes.delete(0);
                    g = '{result_contract, short_change, mid_change, long_change,
                          zero_base_mask, overflow_mask, saturated_mask};
                    if (g.contract !== e.contract)
                        report_mismatch("result_contract", g.contract, e.contract);
                    if (g.chg_s !== e.chg_s)
                        report_mismatch("short_change", g.chg_s, e.chg_s);
                    if (g.chg_m !== e.chg_m)
                        report_mismatch("mid_change", g.chg_m, e.chg_m);
                    if (g.chg_l !== e.chg_l)
                        report_mismatch("long_change", g.chg_l, e.chg_l);
                    if (g.zb !== e.zb)
                        report_mismatch("zero_base_mask", g.zb, e.zb);
                    if (g.ov !== e.ov)
                        report_mismatch("overflow_mask", g.ov, e.ov);
                    if (g.sat !== e.sat)
                        report_mismatch("saturated_mask", g.sat, e.sat);
                end
            end
        end
    end

    initial error_count = 0;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam longint CYCLE_LIMIT = 5000000;

    logic               clk = 0;
    logic               rst_n = 1'b1;
    logic               cfg_we = 0;
    logic [1:0]         cfg_index = wpct_pkg::REG_SHORT;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [5:0]         contract_index = '0;
    logic [31:0]        tick_seconds = '0;
    logic [39:0]        tick_price = '0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [5:0]         result_contract;
    logic signed [20:0] short_change, mid_change, long_change;
    logic [2:0]         zero_base_mask, overflow_mask, saturated_mask;
    int                 error_count;
    int                 pending_count;
    longint             cycles = 0;
    logic [31:0]        clock_now = 32'd1000;
    bit                 stall_run = 0;

    always #2 clk = ~clk;

    windowed_price_change_tracker_unit DUT (.*);
    tick_change_checker u_checker (.*);

    // run-length guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stall: new random gap after every accepted word, none while stall_run is set
    initial
    begin
        int gap;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                gap = stall_run ? 0 : $urandom_range(0, 8);
                if (gap > 0)
                begin
                    out_stall <= 1;
                    repeat (gap) @(posedge clk);
                    out_stall <= 0;
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // drive one tick word, waiting for acceptance; valid stays up for a word that follows
    task automatic send_tick(input logic [5:0] c, input logic [31:0] t, input logic [39:0] p,
                             input int gap);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1; contract_index <= c; tick_seconds <= t; tick_price <= p;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pending_count != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // mostly small time steps on few contracts so windows hold and expire entries
    task automatic random_phase(input int n);
        logic [5:0]  c;
        logic [39:0] p;
        int          r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            c = (r < 70) ? 6'($urandom_range(0, 3)) : 6'($urandom);
            clock_now = clock_now + $urandom_range(0, 40);
            if (r >= 95)
                clock_now = clock_now - $urandom_range(0, 200);
            case ($urandom_range(0, 5))
                0: p = '0;
                1: p = 40'({$urandom, $urandom});
                2: p = 40'($urandom_range(1, 20));
                default: p = 40'd1000000 + 40'($urandom_range(0, 200000));
            endcase
            send_tick(c, (r == 99) ? $urandom : clock_now, p,
                      stall_run ? 0 : $urandom_range(0, 8));
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero base, huge rise, full drop, tiny negative, far contract
        send_tick(6'd0, 32'd100, 40'd0, 0);
        send_tick(6'd0, 32'd101, 40'd5000, 0);
        send_tick(6'd1, 32'd100, 40'd1, 0);
        send_tick(6'd1, 32'd101, 40'hFF_FFFF_FFFF, 0);
        send_tick(6'd1, 32'd102, 40'd0, 1);
        send_tick(6'd2, 32'd100, 40'd1000000, 0);
        send_tick(6'd2, 32'd101, 40'd999999, 0);
        send_tick(6'd2, 32'd102, 40'd1000050, 0);
        send_tick(6'd2, 32'd90, 40'd1000000, 0);
        send_tick(6'd2, 32'hFFFF_FFFF, 40'd2000000, 0);
        send_tick(6'd2, 32'd0, 40'd3000000, 0);
        send_tick(6'd63, 32'd5, 40'd7, 0);
        send_tick(6'd63, 32'd500, 40'd8, 0);
        // fill one ring past its depth for the overflow flag
        for (int i = 0; i < wpct_pkg::RING_DEPTH_DEF + 4; i++)
            send_tick(6'd5, 32'd2000, 40'(100 + i), 0);
        drain();

        // extremes of the window registers
        write_reg(wpct_pkg::REG_SHORT, 16'd0);
        write_reg(wpct_pkg::REG_MID, 16'd1);
        write_reg(wpct_pkg::REG_LONG, 16'hFFFF);
        random_phase(180);
        drain();
        write_reg(wpct_pkg::REG_SHORT, 16'd20);
        write_reg(wpct_pkg::REG_MID, 16'd60);
        write_reg(wpct_pkg::REG_LONG, 16'd120);
        stall_run = 1;
        random_phase(100);
        stall_run = 0;
        drain();
        write_reg(wpct_pkg::REG_SHORT, 16'($urandom_range(1, 100)));
        write_reg(wpct_pkg::REG_MID, 16'($urandom_range(1, 400)));
        write_reg(wpct_pkg::REG_LONG, 16'($urandom));
        random_phase(220);
        drain();
        write_reg(wpct_pkg::REG_SHORT, wpct_pkg::SHORT_RESET);
        write_reg(wpct_pkg::REG_MID, wpct_pkg::MID_RESET);
        write_reg(wpct_pkg::REG_LONG, wpct_pkg::LONG_RESET);
        random_phase(180);
        drain();

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
rtl/wpct_pkg.sv
rtl/windowed_price_change_tracker_unit.sv
sim/tick_change_checker.sv
sim/tb_top.sv
